>>> sv/gcfp_pkg.sv
// ----------------------------------------------------------------------------
// gcfp_pkg
// Shared types, constants and hex helpers for the gimbal command frame parser.
// ----------------------------------------------------------------------------
package gcfp_pkg;

   localparam int MAX_FRAME_LEN  = 32;
   localparam int FRAME_OVERHEAD = 12;
   localparam int WIN_DEPTH      = 6;
   localparam int WIN_IDX_W      = $clog2(WIN_DEPTH);
   localparam int FILL_W         = $clog2(WIN_DEPTH + 1);
   localparam int ADDR_POS       = 4;
   localparam int LEN_POS        = 5;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W          = 5;
   localparam int LEN_CHK_W      = 7;

   localparam logic [POS_W-1:0] START_POS  = 5'd6;
   localparam logic [POS_W-1:0] CMD_POS    = 5'd7;
   localparam logic [POS_W-1:0] ARG_HI_POS = 5'd10;
   localparam logic [POS_W-1:0] ARG_LO_POS = 5'd11;

   localparam logic [7:0]  SYNC_CHAR  = 8'h23;
   localparam logic [7:0]  CENTER_ARG = 8'h05;
   localparam logic [3:0]  NIBBLE_MASK = 4'hf;
   localparam logic [23:0] STR_GAA = "GAA";
   localparam logic [23:0] STR_VER = "VER";
   localparam logic [23:0] STR_SDC = "SDC";
   localparam logic [23:0] STR_MOD = "MOD";
   localparam logic [23:0] STR_GSY = "GSY";
   localparam logic [23:0] STR_GSP = "GSP";
   localparam logic [23:0] STR_PTZ = "PTZ";

   typedef enum logic [2:0] {
      CMD_OTHER = 3'd0,
      CMD_GAA   = 3'd1,
      CMD_VER   = 3'd2,
      CMD_SDC   = 3'd3,
      CMD_MOD   = 3'd4,
      CMD_GSY   = 3'd5,
      CMD_GSP   = 3'd6,
      CMD_PTZ   = 3'd7
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [7:0]   addr;
      logic [3:0]   len;
      logic [7:0]   arg_hi;
      logic [7:0]   arg_lo;
   } frame_rec_type;

   typedef struct packed {
      logic              idle;
      logic              locked;
      logic [FILL_W-1:0] fill;
   } front_stat_type;

   function automatic logic hex_valid(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [3:0] v;
      if (b >= "0" && b <= "9") begin
         v = b[3:0];
      end else begin
         v = b[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      logic [3:0] n;
      logic [7:0] c;
      n = nib & NIBBLE_MASK;
      if (n < 4'd10) begin
         c = 8'h30 + {4'b0, n};
      end else begin
         c = 8'h37 + {4'b0, n};
      end
      return c;
   endfunction

endpackage

>>> sv/gimbal_command_frame_parser_core.sv
// ----------------------------------------------------------------------------
// gimbal_command_frame_parser_core
// Serial gimbal command frame parser with byte-sum check and command decode.
// ----------------------------------------------------------------------------
// Push one received byte per request. A byte inside the frame body is accepted
// with no header check. A header byte is accepted and then goes through the
// header check. A header failure adds a resync. The resync drops one buffered
// byte a cycle, and each further header failure on the rescanned bytes adds
// another drop, scan and check. The longest stall comes from a length digit
// rejected with all six header bytes held, where the rescan then fails the
// header a second time. Each frame that passes its checksum yields one
// request on the result side. It carries the command code, the address byte,
// the length digit and the yaw, pitch and centering state after the command.
// Failed frames vanish. A two-entry queue separates intake from execution, and
// the result sits in an output register, so bytes keep flowing while a result
// waits to be popped.
module gimbal_command_frame_parser_core import gcfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        req_rx_byte,
   output logic              empty,
   input  logic              pop,
   output logic [2:0]        rsp_cmd_code,
   output logic [7:0]        rsp_addr_byte,
   output logic [3:0]        rsp_data_length,
   output logic signed [7:0] rsp_yaw_speed,
   output logic signed [7:0] rsp_pitch_speed,
   output logic              rsp_centering
);

   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;
   frame_rec_type  q_wr_data;
   frame_rec_type  q_rd_data;
   front_stat_type front_stat;

   gcfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .rx_byte  (req_rx_byte),
      .rec_push (q_push),
      .rec      (q_wr_data),
      .rec_full (q_full),
      .stat     (front_stat)
   );

   gcfp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   gcfp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rec_valid       (!q_empty),
      .rec             (q_rd_data),
      .rec_take        (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_cmd_code    (rsp_cmd_code),
      .rsp_addr_byte   (rsp_addr_byte),
      .rsp_data_length (rsp_data_length),
      .rsp_yaw_speed   (rsp_yaw_speed),
      .rsp_pitch_speed (rsp_pitch_speed),
      .rsp_centering   (rsp_centering)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("frame record pushed into a full queue");

   a_frame_clears_front: assert property (@(posedge clock) disable iff (reset)
      q_push |=> (front_stat.fill == '0) && !front_stat.locked)
      else $error("front not cleared after a completed frame");

   a_result_from_queue: assert property (@(posedge clock) disable iff (reset)
      (!empty && $past(empty || pop)) |-> $past(q_pop))
      else $error("new result without a queue pop");

endmodule

>>> sv/gcfp_front.sv
// ----------------------------------------------------------------------------
// gcfp_front
// Byte intake: header window, resync, body tracking, sum check, command class.
// ----------------------------------------------------------------------------
module gcfp_front import gcfp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [7:0]     rx_byte,
   output logic           rec_push,
   output frame_rec_type  rec,
   input  logic           rec_full,
   output front_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DROP  = 4'b0100,
      ST_SCAN  = 4'b1000
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              locked_ff, locked_in;
   logic [7:0]        win_ff [WIN_DEPTH];
   logic [7:0]        win_in [WIN_DEPTH];
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  plen_ff, plen_in;
   logic [3:0]        len_ff, len_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        ck_hi_ff, ck_hi_in;
   logic [23:0]       cmd_ff, cmd_in;
   logic [7:0]        arg_hi_ff, arg_hi_in;
   logic [7:0]        arg_lo_ff, arg_lo_in;

   logic                 accept;
   logic                 last;
   logic                 head_bad;
   logic                 len_ok;
   logic [3:0]           len_dig;
   logic [LEN_CHK_W-1:0] plen_wide;
   logic                 too_long;
   logic [7:0]           hdr_sum;
   logic                 sum_match;
   logic                 long_arg;
   cmd_code_type         code;

   assign last     = locked_ff && (pos_ff == plen_ff - 5'd1);
   assign full     = (state_ff != ST_IDLE) || (last && rec_full);
   assign accept   = push && !full;

   assign head_bad = (win_ff[0] != SYNC_CHAR) ||
                     !(win_ff[1] == "T" || win_ff[1] == "t") ||
                     !(win_ff[2] == "P" || win_ff[2] == "p");
   assign len_ok    = hex_valid(win_ff[LEN_POS]);
   assign len_dig   = hex_nibble(win_ff[LEN_POS]);
   assign plen_wide = LEN_CHK_W'(FRAME_OVERHEAD) + {3'b0, len_dig};
   assign too_long  = plen_wide > LEN_CHK_W'(MAX_FRAME_LEN);

   always_comb begin
      hdr_sum = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         hdr_sum = hdr_sum + win_ff[i];
      end
   end

   assign sum_match = (ck_hi_ff == hex_upper(sum_ff[7:4])) &&
                      (rx_byte == hex_upper(sum_ff[3:0]));
   assign long_arg  = len_ff >= 4'd2;

   always_comb begin
      if (cmd_ff == STR_GAA) begin
         code = CMD_GAA;
      end else if (cmd_ff == STR_VER) begin
         code = CMD_VER;
      end else if (cmd_ff == STR_SDC) begin
         code = CMD_SDC;
      end else if (cmd_ff == STR_MOD) begin
         code = CMD_MOD;
      end else if (cmd_ff == STR_GSY && long_arg) begin
         code = CMD_GSY;
      end else if (cmd_ff == STR_GSP && long_arg) begin
         code = CMD_GSP;
      end else if (cmd_ff == STR_PTZ && long_arg) begin
         code = CMD_PTZ;
      end else begin
         code = CMD_OTHER;
      end
   end

   always_comb begin
      rec.code   = code;
      rec.addr   = win_ff[ADDR_POS];
      rec.len    = len_ff;
      rec.arg_hi = arg_hi_ff;
      rec.arg_lo = (pos_ff == ARG_LO_POS) ? rx_byte : arg_lo_ff;
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      locked_in = locked_ff;
      win_in    = win_ff;
      pos_in    = pos_ff;
      plen_in   = plen_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      ck_hi_in  = ck_hi_ff;
      cmd_in    = cmd_ff;
      arg_hi_in = arg_hi_ff;
      arg_lo_in = arg_lo_ff;
      rec_push  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (locked_ff) begin
                  pos_in = pos_ff + 5'd1;
                  if (pos_ff < plen_ff - 5'd2) begin
                     sum_in = sum_ff + rx_byte;
                  end
                  if (pos_ff == plen_ff - 5'd2) begin
                     ck_hi_in = rx_byte;
                  end
                  if (pos_ff >= CMD_POS && pos_ff < ARG_HI_POS) begin
                     cmd_in = {cmd_ff[15:0], rx_byte};
                  end
                  if (pos_ff == ARG_HI_POS) begin
                     arg_hi_in = rx_byte;
                  end
                  if (pos_ff == ARG_LO_POS) begin
                     arg_lo_in = rx_byte;
                  end
                  if (last) begin
                     locked_in = 1'b0;
                     fill_in   = '0;
                     rec_push  = sum_match;
                  end
               end else begin
                  win_in[fill_ff[WIN_IDX_W-1:0]] = rx_byte;
                  fill_in  = fill_ff + 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (fill_ff >= FILL_W'(3) && head_bad) begin
               state_in = ST_DROP;
            end else if (fill_ff == FILL_W'(WIN_DEPTH)) begin
               if (!len_ok || too_long) begin
                  state_in = ST_DROP;
               end else begin
                  locked_in = 1'b1;
                  len_in    = len_dig;
                  plen_in   = plen_wide[POS_W-1:0];
                  sum_in    = hdr_sum;
                  pos_in    = START_POS;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DROP: begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            fill_in  = fill_ff - 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (fill_ff != '0 && win_ff[0] != SYNC_CHAR) begin
               for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               fill_in = fill_ff - 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         locked_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         locked_ff <= locked_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      pos_ff    <= pos_in;
      plen_ff   <= plen_in;
      len_ff    <= len_in;
      sum_ff    <= sum_in;
      ck_hi_ff  <= ck_hi_in;
      cmd_ff    <= cmd_in;
      arg_hi_ff <= arg_hi_in;
      arg_lo_ff <= arg_lo_in;
   end

   assign stat.idle   = (state_ff == ST_IDLE);
   assign stat.locked = locked_ff;
   assign stat.fill   = fill_ff;

endmodule

>>> sv/gcfp_queue.sv
// ----------------------------------------------------------------------------
// gcfp_queue
// Short queue of checked frame records between intake and command execution.
// ----------------------------------------------------------------------------
module gcfp_queue import gcfp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  frame_rec_type wr_data,
   output logic          full,
   input  logic          rd_en,
   output frame_rec_type rd_data,
   output logic          empty
);

   frame_rec_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/gcfp_back.sv
// ----------------------------------------------------------------------------
// gcfp_back
// Command execution: speed and centering state, registered request output.
// ----------------------------------------------------------------------------
module gcfp_back import gcfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_valid,
   input  frame_rec_type     rec,
   output logic              rec_take,
   output logic              empty,
   input  logic              pop,
   output logic [2:0]        rsp_cmd_code,
   output logic [7:0]        rsp_addr_byte,
   output logic [3:0]        rsp_data_length,
   output logic signed [7:0] rsp_yaw_speed,
   output logic signed [7:0] rsp_pitch_speed,
   output logic              rsp_centering
);

   logic [7:0]   yaw_ff, yaw_in;
   logic [7:0]   pitch_ff, pitch_in;
   logic         cent_ff, cent_in;
   logic         out_valid_ff, out_valid_in;
   cmd_code_type out_code_ff;
   logic [7:0]   out_addr_ff;
   logic [3:0]   out_len_ff;
   logic [7:0]   out_yaw_ff;
   logic [7:0]   out_pitch_ff;
   logic         out_cent_ff;

   logic         arg_ok;
   logic [7:0]   arg_val;

   assign rec_take = rec_valid && (!out_valid_ff || pop);
   assign arg_ok   = hex_valid(rec.arg_hi) && hex_valid(rec.arg_lo);
   assign arg_val  = {hex_nibble(rec.arg_hi), hex_nibble(rec.arg_lo)};

   always_comb begin
      yaw_in   = yaw_ff;
      pitch_in = pitch_ff;
      cent_in  = cent_ff;
      if (rec_take) begin
         unique case (rec.code)
            CMD_GSY: begin
               cent_in = 1'b0;
               if (arg_ok) begin
                  yaw_in = arg_val;
               end
            end
            CMD_GSP: begin
               cent_in = 1'b0;
               if (arg_ok) begin
                  pitch_in = arg_val;
               end
            end
            CMD_PTZ: begin
               if (arg_ok && arg_val == CENTER_ARG) begin
                  cent_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rec_take) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         cent_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         cent_ff      <= cent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         out_code_ff  <= rec.code;
         out_addr_ff  <= rec.addr;
         out_len_ff   <= rec.len;
         out_yaw_ff   <= yaw_in;
         out_pitch_ff <= pitch_in;
         out_cent_ff  <= cent_in;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_cmd_code    = out_code_ff;
   assign rsp_addr_byte   = out_addr_ff;
   assign rsp_data_length = out_len_ff;
   assign rsp_yaw_speed   = out_yaw_ff;
   assign rsp_pitch_speed = out_pitch_ff;
   assign rsp_centering   = out_cent_ff;

endmodule

>>> tb/gimbal_command_frame_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gimbal_command_frame_parser_core_tb
// Streams serial command bytes into the frame parser and checks every decoded
// command against a byte-level frame predictor. Directed frames cover each
// command, speed extremes, the centering rules, short payloads, bad sums and
// broken headers. These are followed by random frames mixed with noise and cut
// frames, under random stalls on both sides.
// ----------------------------------------------------------------------------
module gimbal_command_frame_parser_core_tb;
   import gcfp_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      cmd_code_type      code;
      logic [7:0]        addr;
      logic [3:0]        len;
      logic signed [7:0] yaw;
      logic signed [7:0] pitch;
      logic              ctr;
   } gimbal_status_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              empty;
   logic              pop = 1'b0;
   logic [2:0]        rsp_cmd_code;
   logic [7:0]        rsp_addr_byte;
   logic [3:0]        rsp_data_length;
   logic signed [7:0] rsp_yaw_speed;
   logic signed [7:0] rsp_pitch_speed;
   logic              rsp_centering;

   logic [7:0]        rx_byte_pending[$];
   gimbal_status_type status_expected[$];

   logic [7:0] rx_frame[MAX_FRAME_LEN];
   int         rx_fill = 0;
   logic [7:0] yaw_q = 8'h00;
   logic [7:0] pitch_q = 8'h00;
   logic       center_q = 1'b0;

   int errors = 0;
   int bytes_queued = 0;
   int tx_gap = 0;
   int rx_gap = 0;
   int hold_left = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int stall_cycles = 0;
   bit no_idle = 1'b0;

   gimbal_command_frame_parser_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_cmd_code    (rsp_cmd_code),
      .rsp_addr_byte   (rsp_addr_byte),
      .rsp_data_length (rsp_data_length),
      .rsp_yaw_speed   (rsp_yaw_speed),
      .rsp_pitch_speed (rsp_pitch_speed),
      .rsp_centering   (rsp_centering)
   );

   always #5 clock = ~clock;

   function automatic int hex_digit_value(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] to_hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'("0" + n);
      return 8'("A" + n - 10);
   endfunction

   function automatic logic [7:0] rand_hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'("0" + n);
      if ($urandom_range(0, 1)) return 8'("A" + n - 10);
      return 8'("a" + n - 10);
   endfunction

   function automatic int idle_len();
      int r;
      if (no_idle || hold_left != 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic void drop_to_sync(input int start);
      int i;
      int k;
      i = start;
      while (i < rx_fill && rx_frame[i] != SYNC_CHAR) i++;
      if (i == 0) return;
      if (i > rx_fill) i = rx_fill;
      for (k = 0; k < rx_fill - i; k++) rx_frame[k] = rx_frame[k + i];
      rx_fill -= i;
   endfunction

   function automatic bit frame_decode(input int len);
      int                plen;
      int                hi;
      int                lo;
      int                k;
      logic [7:0]        csum;
      logic [7:0]        arg;
      logic [23:0]       cmd;
      gimbal_status_type st;
      plen = FRAME_OVERHEAD + len;
      csum = 8'h00;
      for (k = 0; k < plen - 2; k++) csum += rx_frame[k];
      if (rx_frame[plen-2] != to_hex_char(csum[7:4]) ||
          rx_frame[plen-1] != to_hex_char(csum[3:0])) return 1'b0;
      hi = hex_digit_value(rx_frame[ARG_HI_POS]);
      lo = hex_digit_value(rx_frame[ARG_LO_POS]);
      arg = {4'(hi), 4'(lo)};
      cmd = {rx_frame[CMD_POS], rx_frame[CMD_POS+1], rx_frame[CMD_POS+2]};
      st.code = CMD_OTHER;
      if (cmd == STR_GAA) begin
         st.code = CMD_GAA;
      end else if (cmd == STR_VER) begin
         st.code = CMD_VER;
      end else if (cmd == STR_SDC) begin
         st.code = CMD_SDC;
      end else if (cmd == STR_MOD) begin
         st.code = CMD_MOD;
      end else if (cmd == STR_GSY && len >= 2) begin
         st.code = CMD_GSY;
         center_q = 1'b0;
         if (hi >= 0 && lo >= 0) yaw_q = arg;
      end else if (cmd == STR_GSP && len >= 2) begin
         st.code = CMD_GSP;
         center_q = 1'b0;
         if (hi >= 0 && lo >= 0) pitch_q = arg;
      end else if (cmd == STR_PTZ && len >= 2) begin
         st.code = CMD_PTZ;
         if (hi >= 0 && lo >= 0 && arg == CENTER_ARG) center_q = 1'b1;
      end
      st.addr  = rx_frame[ADDR_POS];
      st.len   = 4'(len);
      st.yaw   = yaw_q;
      st.pitch = pitch_q;
      st.ctr   = center_q;
      status_expected.push_back(st);
      return 1'b1;
   endfunction

   function automatic void frame_absorb(input logic [7:0] b);
      int len;
      int plen;
      bit got;
      if (rx_fill < MAX_FRAME_LEN) begin
         rx_frame[rx_fill] = b;
         rx_fill++;
      end
      got = 1'b0;
      while (rx_fill >= 3) begin
         if (rx_frame[0] != SYNC_CHAR || !(rx_frame[1] == "T" || rx_frame[1] == "t") ||
             !(rx_frame[2] == "P" || rx_frame[2] == "p")) begin
            drop_to_sync(1);
            continue;
         end
         if (rx_fill < 6) break;
         len = hex_digit_value(rx_frame[LEN_POS]);
         if (len < 0) begin
            drop_to_sync(1);
            continue;
         end
         plen = FRAME_OVERHEAD + len;
         if (plen > MAX_FRAME_LEN) begin
            drop_to_sync(1);
            continue;
         end
         if (rx_fill < plen) break;
         if (!got) got = frame_decode(len);
         drop_to_sync(plen);
      end
   endfunction

   function automatic void queue_frame(input logic [23:0] cmd, input int len,
                                       input logic [7:0] addr, input logic [7:0] arg_hi,
                                       input logic [7:0] arg_lo, input bit bad_sum,
                                       input int cut);
      logic [7:0] fr[$];
      logic [7:0] csum;
      int         k;
      fr.push_back(SYNC_CHAR);
      fr.push_back($urandom_range(0, 1) ? "T" : "t");
      fr.push_back($urandom_range(0, 1) ? "P" : "p");
      fr.push_back(addr);
      fr.push_back(8'($urandom_range(0, 255)));
      fr.push_back(rand_hex_char(4'(len)));
      fr.push_back(8'($urandom_range(0, 255)));
      fr.push_back(cmd[23:16]);
      fr.push_back(cmd[15:8]);
      fr.push_back(cmd[7:0]);
      for (k = 0; k < len; k++) begin
         fr.push_back(k == 0 ? arg_hi : (k == 1 ? arg_lo : 8'($urandom_range(0, 255))));
      end
      csum = 8'h00;
      foreach (fr[j]) csum += fr[j];
      fr.push_back(to_hex_char(csum[7:4]));
      fr.push_back(to_hex_char(csum[3:0]) ^ (bad_sum ? 8'h01 : 8'h00));
      if (cut >= 0) begin
         while (fr.size() > cut) void'(fr.pop_back());
      end
      foreach (fr[j]) rx_byte_pending.push_back(fr[j]);
      bytes_queued += fr.size();
   endfunction

   function automatic void queue_random_frame();
      logic [23:0] cmd;
      logic [7:0]  hi;
      logic [7:0]  lo;
      int          len;
      int          sel;
      int          cut;
      sel = $urandom_range(0, 99);
      if (sel < 8) cmd = STR_GAA;
      else if (sel < 14) cmd = STR_VER;
      else if (sel < 20) cmd = STR_SDC;
      else if (sel < 26) cmd = STR_MOD;
      else if (sel < 50) cmd = STR_GSY;
      else if (sel < 72) cmd = STR_GSP;
      else if (sel < 94) cmd = STR_PTZ;
      else cmd = 24'($urandom);
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 15);
      if (cmd == STR_PTZ && $urandom_range(0, 1)) begin
         hi = "0";
         lo = "5";
      end else if ($urandom_range(0, 9) < 8) begin
         hi = rand_hex_char(4'($urandom));
         lo = rand_hex_char(4'($urandom));
      end else begin
         hi = 8'($urandom);
         lo = 8'($urandom);
      end
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 11 + len) : -1;
      queue_frame(cmd, len, 8'($urandom), hi, lo, $urandom_range(0, 9) == 0, cut);
   endfunction

   function automatic void queue_random_stream(input int count);
      int target;
      int n;
      target = bytes_queued + count;
      while (bytes_queued < target) begin
         if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 5);
            repeat (n) rx_byte_pending.push_back(8'($urandom_range(0, 255)));
            bytes_queued += n;
         end else begin
            queue_random_frame();
         end
      end
   endfunction

   function automatic void field_check(input string name, input logic [7:0] exp,
                                       input logic [7:0] act);
      if (act !== exp) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         errors++;
      end
   endfunction

   function automatic void status_check();
      gimbal_status_type e;
      if (status_expected.size() == 0) begin
         $display("%0t: unexpected request, expected none, actual cmd_code %0d",
                  $time, rsp_cmd_code);
         errors++;
         return;
      end
      e = status_expected.pop_front();
      field_check("cmd_code", 8'(e.code), 8'(rsp_cmd_code));
      field_check("addr_byte", e.addr, rsp_addr_byte);
      field_check("data_length", 8'(e.len), 8'(rsp_data_length));
      field_check("yaw_speed", e.yaw, rsp_yaw_speed);
      field_check("pitch_speed", e.pitch, rsp_pitch_speed);
      field_check("centering", 8'(e.ctr), 8'(rsp_centering));
   endfunction

   task automatic wait_drained();
      while (rx_byte_pending.size() != 0 || push || status_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push   <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (push && !full) frame_absorb(req_rx_byte);
         if (!(push && full)) begin
            if (tx_gap > 0) begin
               push   <= 1'b0;
               tx_gap <= tx_gap - 1;
            end else if (rx_byte_pending.size() != 0) begin
               push        <= 1'b1;
               req_rx_byte <= rx_byte_pending.pop_front();
               tx_gap      <= idle_len();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      int g;
      if (reset) begin
         pop       <= 1'b0;
         rx_gap    <= 0;
         hold_left <= 0;
      end else begin
         if (pop && !empty) status_check();
         if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            pop    <= 1'b0;
         end else if (pop && !empty) begin
            g = idle_len();
            rx_gap <= g;
            pop    <= (g == 0);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // leading junk while the store holds fewer than three bytes
      rx_byte_pending.push_back(8'h00);
      rx_byte_pending.push_back(8'hff);
      queue_frame(STR_GAA, 0, 8'h00, "0", "0", 1'b0, -1);
      queue_frame(STR_VER, 1, 8'hff, "1", "0", 1'b0, -1);
      queue_frame(STR_SDC, 3, 8'h5a, "0", "0", 1'b0, -1);
      queue_frame(STR_MOD, 2, 8'ha5, "0", "1", 1'b0, -1);
      queue_frame(STR_GSY, 2, 8'h01, "7", "F", 1'b0, -1);
      queue_frame(STR_GSP, 2, 8'h02, "8", "0", 1'b0, -1);
      queue_frame(STR_PTZ, 2, 8'h03, "0", "5", 1'b0, -1);
      queue_frame(STR_PTZ, 2, 8'h04, "0", "6", 1'b0, -1);
      queue_frame(STR_GSY, 2, 8'h05, "f", "f", 1'b0, -1);
      queue_frame(STR_PTZ, 3, 8'h06, "0", "5", 1'b0, -1);
      queue_frame(STR_GSP, 2, 8'h07, "G", "1", 1'b0, -1);
      queue_frame(STR_GSY, 1, 8'h08, "3", "3", 1'b0, -1);
      queue_frame(STR_PTZ, 0, 8'h09, "0", "5", 1'b0, -1);
      queue_frame("XYZ", 4, 8'h0a, "1", "2", 1'b0, -1);
      queue_frame(STR_GSY, 15, 8'h0b, "0", "0", 1'b0, -1);
      queue_frame(STR_GSY, 2, 8'h0c, "1", "1", 1'b1, -1);
      // broken header byte two, then a bad length digit
      rx_byte_pending.push_back(SYNC_CHAR);
      rx_byte_pending.push_back("T");
      rx_byte_pending.push_back("X");
      queue_frame(STR_GSP, 2, 8'h0d, "0", "a", 1'b0, -1);
      rx_byte_pending.push_back(SYNC_CHAR);
      rx_byte_pending.push_back("t");
      rx_byte_pending.push_back("p");
      rx_byte_pending.push_back(8'h41);
      rx_byte_pending.push_back(8'h42);
      rx_byte_pending.push_back("G");
      queue_frame(STR_PTZ, 2, 8'h0e, "0", "5", 1'b0, -1);
      // cut frame with a sync byte in the address, then a good one
      queue_frame(STR_GSY, 2, SYNC_CHAR, "4", "0", 1'b0, 5);
      queue_frame(STR_GSY, 2, 8'h80, "C", "0", 1'b0, -1);
      wait_drained();

      // long receiver hold while the sender keeps offering
      queue_random_stream(400);
      while (rx_byte_pending.size() > 300) @(negedge clock);
      hold_req = hold_req + 1;
      wait_drained();

      no_idle = 1'b1;
      queue_random_stream(200);
      wait_drained();
      no_idle = 1'b0;

      queue_random_stream(400);
      wait_drained();
      repeat (40) @(negedge clock);

      if (status_expected.size() != 0) begin
         $display("%0t: %0d expected requests never arrived", $time, status_expected.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/gcfp_pkg.sv
sv/gcfp_front.sv
sv/gcfp_queue.sv
sv/gcfp_back.sv
sv/gimbal_command_frame_parser_core.sv
tb/gimbal_command_frame_parser_core_tb.sv
